### src/hrp_pkg.sv
// hrp_pkg: shared types and constants of the http byte range parser
// holds the input beat and result record structs, status codes and prefix text
// no dependencies
package hrp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [63:0] first_byte;
        logic [63:0] last_byte;
        logic [2:0]  status;
        logic        final_record;
    } out_rec_t;

    localparam logic KIND_RANGE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_PREFIX = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_BAD_DIGIT  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_DIGIT = 2'd1;
    localparam logic [1:0] FAULT_OVER  = 2'd2;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // output queue depth, two slots kept free for a worst-case beat
    localparam int OUT_DEPTH = 4;

    // expected lower-case character of "bytes=" at a prefix position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            3'd5:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### src/hrp_parse.sv
// hrp_parse: parser state and single-pass per-character update
// produces up to two result records per beat; depends on hrp_pkg
module hrp_parse (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  hrp_pkg::in_item_t item,
    output hrp_pkg::out_rec_t rec0,
    output hrp_pkg::out_rec_t rec1,
    output logic [1:0]       rec_cnt
);

    logic [2:0]  prefix_pos_reg, prefix_pos_next;
    logic [2:0]  error_code_reg, error_code_next;
    logic        in_upper_reg, in_upper_next;
    logic [63:0] lower_value_reg, lower_value_next;
    logic        lower_present_reg, lower_present_next;
    logic [1:0]  lower_fault_reg, lower_fault_next;
    logic [63:0] upper_value_reg, upper_value_next;
    logic        upper_present_reg, upper_present_next;
    logic [1:0]  upper_fault_reg, upper_fault_next;

    logic [7:0]  lc;
    logic        is_digit;
    logic [3:0]  digit;
    logic [63:0] acc_sel;
    logic [1:0]  fault_sel;
    logic [67:0] acc_wide;
    logic [67:0] prod;
    logic [63:0] acc_new;
    logic [1:0]  fault_new;
    logic        comma_v;
    logic        final_v;
    hrp_pkg::out_rec_t comma_rec;
    hrp_pkg::out_rec_t final_rec;
    hrp_pkg::out_rec_t stat_rec;

    function automatic logic [2:0] fault_status(input logic [1:0] f);
        return (f == hrp_pkg::FAULT_DIGIT) ? hrp_pkg::ST_BAD_DIGIT : hrp_pkg::ST_OVERFLOW;
    endfunction

    // one shared times-ten accumulate for whichever bound is open
    always_comb begin
        lc = item.char_code;
        if (item.char_code >= hrp_pkg::CH_UPPER_A && item.char_code <= hrp_pkg::CH_UPPER_Z) begin
            lc = item.char_code | hrp_pkg::CASE_BIT;
        end
        is_digit  = (item.char_code >= hrp_pkg::CH_ZERO) && (item.char_code <= hrp_pkg::CH_NINE);
        digit     = item.char_code[3:0];
        acc_sel   = in_upper_reg ? upper_value_reg : lower_value_reg;
        fault_sel = in_upper_reg ? upper_fault_reg : lower_fault_reg;
        acc_wide  = {4'b0, acc_sel};
        prod      = (acc_wide << 3) + (acc_wide << 1) + {64'b0, digit};
        acc_new   = acc_sel;
        fault_new = fault_sel;
        if (fault_sel != hrp_pkg::FAULT_DIGIT) begin
            if (!is_digit) begin
                fault_new = hrp_pkg::FAULT_DIGIT;
            end else if (fault_sel != hrp_pkg::FAULT_OVER) begin
                if (prod[67:64] != 4'b0) begin
                    acc_new   = '1;
                    fault_new = hrp_pkg::FAULT_OVER;
                end else begin
                    acc_new = prod[63:0];
                end
            end
        end
    end

    always_comb begin
        prefix_pos_next    = prefix_pos_reg;
        error_code_next    = error_code_reg;
        in_upper_next      = in_upper_reg;
        lower_value_next   = lower_value_reg;
        lower_present_next = lower_present_reg;
        lower_fault_next   = lower_fault_reg;
        upper_value_next   = upper_value_reg;
        upper_present_next = upper_present_reg;
        upper_fault_next   = upper_fault_reg;
        comma_v            = 1'b0;
        final_v            = 1'b0;

        comma_rec              = '0;
        comma_rec.record_kind  = hrp_pkg::KIND_RANGE;
        comma_rec.first_byte   = lower_value_reg;
        comma_rec.last_byte    = upper_value_reg;
        comma_rec.status       = hrp_pkg::ST_OK;

        if (error_code_reg == hrp_pkg::ST_OK) begin
            if (prefix_pos_reg < hrp_pkg::PREFIX_LEN) begin
                if (lc == hrp_pkg::prefix_char(prefix_pos_reg)) begin
                    prefix_pos_next = prefix_pos_reg + 3'd1;
                end else begin
                    error_code_next = hrp_pkg::ST_BAD_PREFIX;
                end
            end else if (item.char_code == hrp_pkg::CH_SPACE) begin
                // skipped
            end else if (item.char_code == hrp_pkg::CH_COMMA) begin
                if (!lower_present_reg || !upper_present_reg) begin
                    error_code_next = hrp_pkg::ST_EMPTY;
                end else if (lower_fault_reg != hrp_pkg::FAULT_NONE) begin
                    error_code_next = fault_status(lower_fault_reg);
                end else if (upper_fault_reg != hrp_pkg::FAULT_NONE) begin
                    error_code_next = fault_status(upper_fault_reg);
                end else begin
                    comma_v            = 1'b1;
                    in_upper_next      = 1'b0;
                    lower_value_next   = '0;
                    lower_present_next = 1'b0;
                    lower_fault_next   = hrp_pkg::FAULT_NONE;
                    upper_value_next   = '0;
                    upper_present_next = 1'b0;
                    upper_fault_next   = hrp_pkg::FAULT_NONE;
                end
            end else if (item.char_code == hrp_pkg::CH_HYPHEN) begin
                in_upper_next = 1'b1;
            end else if (in_upper_reg) begin
                upper_value_next   = acc_new;
                upper_present_next = 1'b1;
                upper_fault_next   = fault_new;
            end else begin
                lower_value_next   = acc_new;
                lower_present_next = 1'b1;
                lower_fault_next   = fault_new;
            end
        end

        final_rec             = '0;
        final_rec.record_kind = hrp_pkg::KIND_RANGE;
        final_rec.first_byte  = lower_value_next;
        final_rec.last_byte   = upper_value_next;
        final_rec.status      = hrp_pkg::ST_OK;

        if (item.end_of_text) begin
            if (error_code_next == hrp_pkg::ST_OK && prefix_pos_next < hrp_pkg::PREFIX_LEN) begin
                error_code_next = hrp_pkg::ST_BAD_PREFIX;
            end
            if (error_code_next == hrp_pkg::ST_OK && lower_present_next) begin
                if (lower_fault_next != hrp_pkg::FAULT_NONE) begin
                    error_code_next = fault_status(lower_fault_next);
                end else begin
                    final_v = 1'b1;
                end
            end
        end

        stat_rec              = '0;
        stat_rec.record_kind  = hrp_pkg::KIND_STATUS;
        stat_rec.status       = error_code_next;
        stat_rec.final_record = 1'b1;

        // a comma record and a final pair never come from the same beat
        rec0    = comma_v ? comma_rec : (final_v ? final_rec : stat_rec);
        rec1    = stat_rec;
        rec_cnt = {1'b0, comma_v} + {1'b0, final_v} + {1'b0, item.end_of_text};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_pos_reg    <= '0;
            error_code_reg    <= hrp_pkg::ST_OK;
            in_upper_reg      <= 1'b0;
            lower_value_reg   <= '0;
            lower_present_reg <= 1'b0;
            lower_fault_reg   <= hrp_pkg::FAULT_NONE;
            upper_value_reg   <= '0;
            upper_present_reg <= 1'b0;
            upper_fault_reg   <= hrp_pkg::FAULT_NONE;
        end else if (fire) begin
            if (item.end_of_text) begin
                prefix_pos_reg    <= '0;
                error_code_reg    <= hrp_pkg::ST_OK;
                in_upper_reg      <= 1'b0;
                lower_value_reg   <= '0;
                lower_present_reg <= 1'b0;
                lower_fault_reg   <= hrp_pkg::FAULT_NONE;
                upper_value_reg   <= '0;
                upper_present_reg <= 1'b0;
                upper_fault_reg   <= hrp_pkg::FAULT_NONE;
            end else begin
                prefix_pos_reg    <= prefix_pos_next;
                error_code_reg    <= error_code_next;
                in_upper_reg      <= in_upper_next;
                lower_value_reg   <= lower_value_next;
                lower_present_reg <= lower_present_next;
                lower_fault_reg   <= lower_fault_next;
                upper_value_reg   <= upper_value_next;
                upper_present_reg <= upper_present_next;
                upper_fault_reg   <= upper_fault_next;
            end
        end
    end

endmodule

### src/hrp_out_fifo.sv
// hrp_out_fifo: small register queue for result records
// takes up to two records per cycle, gives one per cycle while m_ready is high; depends on hrp_pkg
module hrp_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  hrp_pkg::out_rec_t wr_rec0,
    input  hrp_pkg::out_rec_t wr_rec1,
    input  logic [1:0]        wr_cnt,
    output logic              room2,
    output hrp_pkg::out_rec_t m_record,
    output logic              m_valid,
    input  logic              m_ready
);

    localparam int PtrW = $clog2(hrp_pkg::OUT_DEPTH);

    hrp_pkg::out_rec_t     slot_reg [hrp_pkg::OUT_DEPTH];
    logic [PtrW-1:0]       wr_ptr_reg;
    logic [PtrW-1:0]       rd_ptr_reg;
    logic [PtrW:0]         count_reg;
    logic [PtrW-1:0]       wr_ptr_p1;
    logic                  pop;

    assign pop       = m_valid && m_ready;
    assign m_valid   = (count_reg != '0);
    assign m_record  = slot_reg[rd_ptr_reg];
    assign room2     = (count_reg <= (PtrW+1)'(hrp_pkg::OUT_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + PtrW'(1);

    always_ff @(posedge aclk) begin
        if (wr_cnt != 2'd0) begin
            slot_reg[wr_ptr_reg] <= wr_rec0;
        end
        if (wr_cnt == 2'd2) begin
            slot_reg[wr_ptr_p1] <= wr_rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PtrW'(wr_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_reg + (PtrW+1)'(wr_cnt) - (PtrW+1)'(pop);
        end
    end

endmodule

### src/http_byte_range_parser.sv
// http_byte_range_parser: top level of the range header parser
// input register, hrp_parse single-pass update and hrp_out_fifo; uses hrp_pkg
//
//  port group  dir  payload                         handshake
//  s_          in   in_item_t  (char, end flag)     s_valid / s_ready
//  m_          out  out_rec_t  (range or status)    m_valid / m_ready
//
// one character per cycle while s_ready is high: a beat is accepted into the
// input register, is parsed and queued, and its records reach m_ from the queue.
// a beat yields up to two records; m_ drains one record per cycle while m_ready
// is high, so the record rate of the output port sets the sustained figure.
// reset (aresetn low, synchronous) empties the pipe and the queue.
// s_ready drops only while the queue has fewer than two free slots.
module http_byte_range_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hrp_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output hrp_pkg::out_rec_t m_record
);

    logic              in_valid_reg;
    hrp_pkg::in_item_t in_item_reg;
    logic              room2;
    logic              fire;
    hrp_pkg::out_rec_t rec0;
    hrp_pkg::out_rec_t rec1;
    logic [1:0]        rec_cnt;
    logic [1:0]        push_cnt;

    assign fire     = in_valid_reg && room2;
    assign s_ready  = !in_valid_reg || room2;
    assign push_cnt = fire ? rec_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    hrp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .rec0    (rec0),
        .rec1    (rec1),
        .rec_cnt (rec_cnt)
    );

    hrp_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_rec0  (rec0),
        .wr_rec1  (rec1),
        .wr_cnt   (push_cnt),
        .room2    (room2),
        .m_record (m_record),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

endmodule

### tb/http_byte_range_parser_test.sv
// http_byte_range_parser_test: self-checking bench for the range header parser
// feeds header bytes through s_, predicts range and status records, checks m_ beats
// depends on hrp_pkg and http_byte_range_parser
`timescale 1ns / 100ps

module http_byte_range_parser_test;

    localparam int          TOTAL_ITEMS      = 1900;
    localparam int          LONG_HOLD_CYCLES = 80;
    localparam logic [47:0] RANGE_UNIT       = "bytes=";
    localparam logic [63:0] ALL_ONES         = '1;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eot;
        logic        typed;      // expected records given in the row
        logic        has_range;
        logic [63:0] first;
        logic [63:0] last;
        logic [2:0]  status;
    } stim_row_t;

    // short headers: bad first char, early end, pair rules, final open pair
    stim_row_t directed_rows [26] = '{
        '{8'hFF, 1, 1, 0, 0, 0, hrp_pkg::ST_BAD_PREFIX},
        '{"B",   1, 1, 0, 0, 0, hrp_pkg::ST_BAD_PREFIX},
        '{"b", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"Y", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"t", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"e", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"S", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"=", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"1", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"-", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"-", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"2", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{",", 0, 1, 1, 1, 2, hrp_pkg::ST_OK},
        '{"+", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"-", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"3", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{",", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"9", 1, 1, 0, 0, 0, hrp_pkg::ST_BAD_DIGIT},
        '{"B", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"y", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"T", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"E", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"S", 0, 0, 0, 0, 0, hrp_pkg::ST_OK}, '{"=", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"5", 0, 0, 0, 0, 0, hrp_pkg::ST_OK},
        '{"-", 1, 1, 1, 5, 0, hrp_pkg::ST_OK}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    hrp_pkg::in_item_t s_item;
    logic              m_valid;
    logic              m_ready;
    hrp_pkg::out_rec_t m_record;

    // parser state mirror
    logic [2:0]  prefix_count;
    logic [2:0]  header_status;
    logic        in_upper;
    logic [63:0] lower_val;
    logic        lower_seen;
    logic [1:0]  lower_flt;
    logic [63:0] upper_val;
    logic        upper_seen;
    logic [1:0]  upper_flt;

    hrp_pkg::out_rec_t char_records[$];
    hrp_pkg::out_rec_t expected_records[$];
    logic [7:0]        header_text[$];

    int error_count       = 0;
    int items_sent        = 0;
    bit sender_calm       = 0;
    bit quiet_tail        = 0;
    bit long_hold_request = 0;

    http_byte_range_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_record (m_record)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("http_byte_range_parser test failed");
        $finish;
    end

    function automatic logic [2:0] fault_to_status(input logic [1:0] flt);
        return (flt == hrp_pkg::FAULT_DIGIT) ? hrp_pkg::ST_BAD_DIGIT : hrp_pkg::ST_OVERFLOW;
    endfunction

    function automatic void add_record(input logic kind, input logic [63:0] first,
                                       input logic [63:0] last, input logic [2:0] status);
        hrp_pkg::out_rec_t rec;
        rec.record_kind  = kind;
        rec.first_byte   = first;
        rec.last_byte    = last;
        rec.status       = status;
        rec.final_record = (kind == hrp_pkg::KIND_STATUS);
        char_records.insert(char_records.size(), rec);
    endfunction

    function automatic void clear_pair();
        in_upper   = 1'b0;
        lower_val  = '0;
        lower_seen = 1'b0;
        lower_flt  = hrp_pkg::FAULT_NONE;
        upper_val  = '0;
        upper_seen = 1'b0;
        upper_flt  = hrp_pkg::FAULT_NONE;
    endfunction

    task automatic take_bound_char(inout logic [63:0] val, inout logic seen,
                                   inout logic [1:0] flt, input logic [7:0] ch);
        logic [63:0] digit;
        seen = 1'b1;
        if (flt != hrp_pkg::FAULT_DIGIT) begin
            if (ch < hrp_pkg::CH_ZERO || ch > hrp_pkg::CH_NINE) begin
                flt = hrp_pkg::FAULT_DIGIT;
            end else if (flt != hrp_pkg::FAULT_OVER) begin
                digit = 64'(ch - hrp_pkg::CH_ZERO);
                if (val > (ALL_ONES - digit) / 64'd10) begin
                    val = ALL_ONES;
                    flt = hrp_pkg::FAULT_OVER;
                end else begin
                    val = val * 64'd10 + digit;
                end
            end
        end
    endtask

    // one header byte through the parser, records land in char_records
    task automatic parse_header_char(input logic [7:0] ch, input logic eot);
        logic [7:0] folded;
        char_records.delete();
        if (header_status == hrp_pkg::ST_OK) begin
            if (prefix_count < hrp_pkg::PREFIX_LEN) begin
                folded = (ch >= hrp_pkg::CH_UPPER_A && ch <= hrp_pkg::CH_UPPER_Z) ?
                         (ch | hrp_pkg::CASE_BIT) : ch;
                if (folded == RANGE_UNIT[8 * (5 - prefix_count) +: 8]) begin
                    prefix_count = prefix_count + 3'd1;
                end else begin
                    header_status = hrp_pkg::ST_BAD_PREFIX;
                end
            end else if (ch == hrp_pkg::CH_SPACE) begin
                // spaces carry no meaning
            end else if (ch == hrp_pkg::CH_COMMA) begin
                if (!lower_seen || !upper_seen) begin
                    header_status = hrp_pkg::ST_EMPTY;
                end else if (lower_flt != hrp_pkg::FAULT_NONE) begin
                    header_status = fault_to_status(lower_flt);
                end else if (upper_flt != hrp_pkg::FAULT_NONE) begin
                    header_status = fault_to_status(upper_flt);
                end else begin
                    add_record(hrp_pkg::KIND_RANGE, lower_val, upper_val, hrp_pkg::ST_OK);
                    clear_pair();
                end
            end else if (ch == hrp_pkg::CH_HYPHEN) begin
                in_upper = 1'b1;
            end else if (in_upper) begin
                take_bound_char(upper_val, upper_seen, upper_flt, ch);
            end else begin
                take_bound_char(lower_val, lower_seen, lower_flt, ch);
            end
        end
        if (eot) begin
            if (header_status == hrp_pkg::ST_OK && prefix_count < hrp_pkg::PREFIX_LEN)
                header_status = hrp_pkg::ST_BAD_PREFIX;
            // open pair goes out unchecked on its upper bound
            if (header_status == hrp_pkg::ST_OK && lower_seen) begin
                if (lower_flt != hrp_pkg::FAULT_NONE)
                    header_status = fault_to_status(lower_flt);
                else
                    add_record(hrp_pkg::KIND_RANGE, lower_val, upper_val, hrp_pkg::ST_OK);
            end
            add_record(hrp_pkg::KIND_STATUS, '0, '0, header_status);
            prefix_count  = '0;
            header_status = hrp_pkg::ST_OK;
            clear_pair();
        end
    endtask

    task automatic send_row(input stim_row_t row);
        hrp_pkg::in_item_t beat;
        hrp_pkg::out_rec_t rec;
        if (!quiet_tail && !sender_calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        beat.char_code = row.ch;
        beat.end_of_text = row.eot;
        s_item  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        parse_header_char(row.ch, row.eot);
        if (row.typed) begin
            if (row.has_range) begin
                rec = '{hrp_pkg::KIND_RANGE, row.first, row.last, hrp_pkg::ST_OK, 1'b0};
                expected_records.insert(expected_records.size(), rec);
            end
            if (row.eot) begin
                rec = '{hrp_pkg::KIND_STATUS, 64'd0, 64'd0, row.status, 1'b1};
                expected_records.insert(expected_records.size(), rec);
            end
        end else begin
            foreach (char_records[i])
                expected_records.insert(expected_records.size(), char_records[i]);
        end
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_records.size() != 0);
    endtask

    task automatic append_text(input string text);
        for (int i = 0; i < text.len(); i++) header_text.insert(header_text.size(), text[i]);
    endtask

    task automatic append_spaces();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                header_text.insert(header_text.size(), hrp_pkg::CH_SPACE);
    endtask

    task automatic append_bound();
        string digits;
        int    pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            digits = "";
        end else if (pick < 4) begin
            // around the 64-bit limit
            case ($urandom_range(0, 3))
                0:       digits = "18446744073709551615";
                1:       digits = "18446744073709551616";
                2:       digits = $sformatf("1844674407370955161%0d", $urandom_range(0, 9));
                default: digits = $sformatf("%0d%0d", {$urandom, $urandom},
                                            $urandom_range(0, 9));
            endcase
        end else begin
            digits = $sformatf("%0d", $urandom_range(0, 10 ** $urandom_range(1, 6) - 1));
            if (pick == 4) digits = {"0", digits};
        end
        append_text(digits);
    endtask

    task automatic build_range_header();
        logic [7:0] ch;
        int         pairs;
        int         damage;
        int         keep;
        header_text.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
                header_text.insert(header_text.size(), 8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i < 6; i++) begin
                ch = RANGE_UNIT[8 * (5 - i) +: 8];
                if (ch != "=" && $urandom_range(0, 1)) ch = ch & ~hrp_pkg::CASE_BIT;
                header_text.insert(header_text.size(), ch);
            end
            pairs = $urandom_range(1, 4);
            for (int p = 0; p < pairs; p++) begin
                if (p > 0) append_text(",");
                append_spaces();
                append_bound();
                append_spaces();
                case ($urandom_range(0, 9))
                    0: begin
                        // pair with no hyphen
                    end
                    1:       append_text("--");
                    default: append_text("-");
                endcase
                append_bound();
                append_spaces();
            end
            if ($urandom_range(0, 7) == 0) append_text(",");
            damage = $urandom_range(0, 9);
            if (damage == 0) begin
                header_text[$urandom_range(0, header_text.size() - 1)] =
                    8'($urandom_range(0, 255));
            end else if (damage == 1) begin
                keep = $urandom_range(1, header_text.size());
                while (header_text.size() > keep) void'(header_text.pop_back());
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : check_records
        hrp_pkg::out_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                report_mismatch("record with nothing pending, status",
                                64'(m_record.status), '0);
            end else begin
                want = expected_records.pop_front();
                if (m_record.record_kind !== want.record_kind)
                    report_mismatch("record_kind", 64'(m_record.record_kind),
                                    64'(want.record_kind));
                if (m_record.first_byte !== want.first_byte)
                    report_mismatch("first_byte", m_record.first_byte, want.first_byte);
                if (m_record.last_byte !== want.last_byte)
                    report_mismatch("last_byte", m_record.last_byte, want.last_byte);
                if (m_record.status !== want.status)
                    report_mismatch("status", 64'(m_record.status), 64'(want.status));
                if (m_record.final_record !== want.final_record)
                    report_mismatch("final_record", 64'(m_record.final_record),
                                    64'(want.final_record));
            end
        end
    end

    // result side back-pressure
    initial begin
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold_request) begin
                long_hold_request = 0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    initial begin
        stim_row_t row;
        bit        hold_done;
        bit        drain_done;
        hold_done  = 0;
        drain_done = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        prefix_count  = '0;
        header_status = hrp_pkg::ST_OK;
        clear_pair();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) send_row(directed_rows[i]);
        wait_for_drain();

        while (items_sent < TOTAL_ITEMS) begin
            build_range_header();
            sender_calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && items_sent > 400) begin
                long_hold_request = 1;
                hold_done = 1;
            end
            if (!drain_done && items_sent > 1000) begin
                wait_for_drain();
                drain_done = 1;
            end
            if (items_sent > TOTAL_ITEMS - 200) quiet_tail = 1;
            foreach (header_text[i]) begin
                row     = '0;
                row.ch  = header_text[i];
                row.eot = (i == header_text.size() - 1);
                send_row(row);
            end
        end

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("http_byte_range_parser test passed");
        else
            $display("http_byte_range_parser test failed");
        $finish;
    end

endmodule
